// ----- hdl/lsf_pkg.sv -----
// Shared widths and constants for the least-squares line fit block.
// Used by lsf_mul, lsf_div, least_squares_line_fit and the testbench; depends on nothing.
package lsf_pkg;

  localparam int unsigned COORD_W = 20;   // Q16.4 sample coordinate
  localparam int unsigned SUM_W   = 36;   // sum of x, sum of y
  localparam int unsigned SQ_W    = 56;   // sum of x*x, sum of x*y, multiplier operand
  localparam int unsigned PROD_W  = 112;  // full product of two SQ_W operands
  localparam int unsigned NUM_W   = 128;  // dividend width of the long divider
  localparam int unsigned DEN_W   = 32;   // divisor width (square root of a 63-bit value)
  localparam int unsigned NRM_W   = 32;   // Q2.30 normal components
  localparam int unsigned OFF_W   = 48;   // Q44.4 line offset

  // Normalized magnitudes land in [2^30, 2^31).
  localparam int unsigned NORM_LO = 30;

  // Products the solve sequence runs through the shared multiplier.
  typedef enum logic [2:0] {
    OP_N_SXY  = 3'd0,
    OP_SX_SY  = 3'd1,
    OP_N_SXX  = 3'd2,
    OP_SX_SX  = 3'd3,
    OP_SXX_SY = 3'd4,
    OP_SX_SXY = 3'd5,
    OP_NA_SQ  = 3'd6,
    OP_D_SQ   = 3'd7
  } mul_op_t;

  // Quotients the solve sequence runs through the divider.
  typedef enum logic [1:0] {
    DV_NX  = 2'd0,
    DV_NY  = 2'd1,
    DV_OFF = 2'd2
  } div_op_t;

endpackage

// ----- hdl/lsf_mul.sv -----
// Iterative signed multiplier, one shift-add step per cycle over the magnitudes.
// Depends on lsf_pkg for operand and product widths.
module lsf_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [lsf_pkg::SQ_W-1:0]     a_in,
  input  logic signed [lsf_pkg::SQ_W-1:0]     b_in,
  output logic                                done,
  output logic signed [lsf_pkg::PROD_W-1:0]   product
);

  localparam int unsigned SQ_W   = lsf_pkg::SQ_W;
  localparam int unsigned PROD_W = lsf_pkg::PROD_W;
  localparam int unsigned CNT_W  = $clog2(SQ_W);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t             state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PROD_W-1:0]   am_r;
  logic [SQ_W-1:0]     bm_r;
  logic [PROD_W-1:0]   acc_r;
  logic                neg_r;
  logic                done_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SQ_W-1:0]     a_mag;
  logic [SQ_W-1:0]     b_mag;

  assign a_mag   = a_in[SQ_W-1] ? SQ_W'(-a_in) : SQ_W'(a_in);
  assign b_mag   = b_in[SQ_W-1] ? SQ_W'(-b_in) : SQ_W'(b_in);
  assign done    = done_r;
  assign product = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            neg_r   <= a_in[SQ_W-1] ^ b_in[SQ_W-1];
            am_r    <= {{(PROD_W-SQ_W){1'b0}}, a_mag};
            bm_r    <= b_mag;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          if (bm_r[0]) begin
            acc_r <= acc_r + am_r;
          end
          am_r  <= {am_r[PROD_W-2:0], 1'b0};
          bm_r  <= {1'b0, bm_r[SQ_W-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SQ_W - 1)) begin
            state_r <= M_FIN;
          end
        end
        M_FIN: begin
          prod_r  <= neg_r ? -acc_r : acc_r;
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/lsf_div.sv -----
// Restoring divider, one quotient bit per cycle, for a wide unsigned dividend.
// Depends on lsf_pkg for dividend and divisor widths.
module lsf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lsf_pkg::NUM_W-1:0]     num_in,
  input  logic [lsf_pkg::DEN_W-1:0]     den_in,
  output logic                          done,
  output logic [lsf_pkg::NUM_W-1:0]     quotient
);

  localparam int unsigned NUM_W = lsf_pkg::NUM_W;
  localparam int unsigned DEN_W = lsf_pkg::DEN_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [DEN_W:0]     rem_sh;
  logic               fits;

  assign rem_sh   = {rem_r, num_r[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, den_r};
  assign done     = done_r;
  assign quotient = num_r;

  // The dividend shifts out of num_r at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          num_r  <= num_in;
          den_r  <= den_in;
          rem_r  <= '0;
          cnt_r  <= '0;
          busy_r <= 1'b1;
        end
      end else begin
        rem_r <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        num_r <= {num_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/least_squares_line_fit.sv -----
// Least-squares line fit: accumulates point sums and solves for the normalized line.
// Depends on lsf_pkg, lsf_mul (shared shift-add multiplier) and lsf_div (long divider).
//
//  channel | direction | tdata (low bit up)                      | side bands
//  --------+-----------+-----------------------------------------+---------------------
//  in_     | input     | sample_x[19:0], sample_y[39:20]         | tlast = last_point
//  out_    | output    | normal_x, normal_y, line_offset (112 b) | tuser = degenerate
//
// For each point, one small 20x20 multiplier forms x*x and then x*y.
// A last point starts the solve, run by the shared shift-add multiplier (8 products, or 6
// for a degenerate set, which then skips the rest), a normalizing shift of one bit a cycle,
// a 32-step square root and three divisions.
// in_tready is low during the solve and while a result waits behind a full output
// register. Reset clears the sums and the point count.
module least_squares_line_fit #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,   // sample_x[19:0], sample_y[39:20]
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // normal_x[31:0], normal_y[63:32], line_offset[111:64]
  output logic [0:0]    out_tuser   // degenerate[0]
);

  localparam int unsigned COORD_W = lsf_pkg::COORD_W;
  localparam int unsigned SUM_W   = lsf_pkg::SUM_W;
  localparam int unsigned SQ_W    = lsf_pkg::SQ_W;
  localparam int unsigned PROD_W  = lsf_pkg::PROD_W;
  localparam int unsigned NUM_W   = lsf_pkg::NUM_W;
  localparam int unsigned DEN_W   = lsf_pkg::DEN_W;
  localparam int unsigned NRM_W   = lsf_pkg::NRM_W;
  localparam int unsigned OFF_W   = lsf_pkg::OFF_W;
  localparam int unsigned NORM_LO = lsf_pkg::NORM_LO;
  localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int unsigned PT_W    = 2 * COORD_W;
  localparam int unsigned SQR_W   = 64;

  typedef enum logic [3:0] {
    ST_IDLE, ST_XY, ST_SXY, ST_MUL, ST_MULW, ST_NORM, ST_SQRT, ST_DIV, ST_DIVW, ST_OUT
  } state_t;

  state_t                      state_r;
  lsf_pkg::mul_op_t            mop_r;
  lsf_pkg::div_op_t            dop_r;

  logic [CNT_W-1:0]            cnt_r;
  logic signed [SUM_W-1:0]     sx_r, sy_r;
  logic signed [SQ_W-1:0]      sxx_r, sxy_r;
  logic signed [COORD_W-1:0]   x_r, y_r;
  logic signed [PT_W-1:0]      prod_r;
  logic                        add_r, last_r;

  logic signed [PROD_W-1:0]    t_r;
  logic [PROD_W-1:0]           ma_r, md_r;
  logic [NUM_W-1:0]            mc_r;
  logic                        na_neg_r, flip_r, nc_neg_r, deg_r;
  logic [SQR_W-1:0]            v_r, res_r, bit_r;
  logic signed [NRM_W-1:0]     nx_r, ny_r;
  logic [OFF_W-1:0]            off_r;

  logic                        out_tvalid_r;
  logic [111:0]                out_tdata_r;
  logic [0:0]                  out_tuser_r;

  // Point path
  logic                        in_acc;
  logic signed [COORD_W-1:0]   in_x, in_y, pm_a, pm_b;
  logic signed [PT_W-1:0]      pm_p;
  logic                        can_add;

  // Shared units
  logic                        mul_start, mul_done;
  logic signed [SQ_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]    mul_p;
  logic signed [PROD_W-1:0]    diff;
  logic [PROD_W-1:0]           diff_mag;
  logic                        div_start, div_done;
  logic [NUM_W-1:0]            div_num, div_q;
  logic [DEN_W-1:0]            root;
  logic [SQR_W-1:0]            trial;
  logic                        norm_big, norm_small;
  logic [OFF_W-1:0]            off_lim, off_mag;
  logic signed [SQ_W-1:0]      n_ext;
  logic                        out_free;

  assign in_x      = in_tdata[COORD_W-1:0];
  assign in_y      = in_tdata[PT_W-1:COORD_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign can_add   = cnt_r < CNT_W'(MAX_POINTS);

  assign pm_a = (state_r == ST_IDLE) ? in_x : x_r;
  assign pm_b = (state_r == ST_IDLE) ? in_x : y_r;
  assign pm_p = pm_a * pm_b;

  assign n_ext = SQ_W'({{(SQ_W-CNT_W){1'b0}}, cnt_r});

  always_comb begin
    unique case (mop_r)
      lsf_pkg::OP_N_SXY:  begin mul_a = n_ext;                 mul_b = sxy_r; end
      lsf_pkg::OP_SX_SY:  begin mul_a = SQ_W'(sx_r);           mul_b = SQ_W'(sy_r); end
      lsf_pkg::OP_N_SXX:  begin mul_a = n_ext;                 mul_b = sxx_r; end
      lsf_pkg::OP_SX_SX:  begin mul_a = SQ_W'(sx_r);           mul_b = SQ_W'(sx_r); end
      lsf_pkg::OP_SXX_SY: begin mul_a = sxx_r;                 mul_b = SQ_W'(sy_r); end
      lsf_pkg::OP_SX_SXY: begin mul_a = SQ_W'(sx_r);           mul_b = sxy_r; end
      lsf_pkg::OP_NA_SQ:  begin
        mul_a = SQ_W'({1'b0, ma_r[NORM_LO:0]});
        mul_b = SQ_W'({1'b0, ma_r[NORM_LO:0]});
      end
      lsf_pkg::OP_D_SQ:   begin
        mul_a = SQ_W'({1'b0, md_r[NORM_LO:0]});
        mul_b = SQ_W'({1'b0, md_r[NORM_LO:0]});
      end
      default:            begin mul_a = '0;                    mul_b = '0; end
    endcase
  end

  assign mul_start = (state_r == ST_MUL);
  assign diff      = t_r - mul_p;
  assign diff_mag  = diff[PROD_W-1] ? PROD_W'(-diff) : PROD_W'(diff);

  lsf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // Normalize until the larger of |NA| and |D| sits in [2^30, 2^31).
  assign norm_big   = (|ma_r[PROD_W-1:NORM_LO+1]) || (|md_r[PROD_W-1:NORM_LO+1]);
  assign norm_small = !norm_big && !ma_r[NORM_LO] && !md_r[NORM_LO];

  assign trial = res_r + bit_r;
  assign root  = res_r[DEN_W-1:0];

  always_comb begin
    unique case (dop_r)
      lsf_pkg::DV_NX:
        div_num = NUM_W'({ma_r[NORM_LO:0], {NORM_LO{1'b0}}}) + NUM_W'(root[DEN_W-1:1]);
      lsf_pkg::DV_NY:
        div_num = NUM_W'({md_r[NORM_LO:0], {NORM_LO{1'b0}}}) + NUM_W'(root[DEN_W-1:1]);
      lsf_pkg::DV_OFF:
        div_num = mc_r + NUM_W'(root[DEN_W-1:1]);
      default:
        div_num = '0;
    endcase
  end

  assign div_start = (state_r == ST_DIV);

  lsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num_in   (div_num),
    .den_in   (root),
    .done     (div_done),
    .quotient (div_q)
  );

  assign off_lim = nc_neg_r ? {1'b1, {(OFF_W-1){1'b0}}} : {1'b0, {(OFF_W-1){1'b1}}};
  assign off_mag = ((|div_q[NUM_W-1:OFF_W]) || (div_q[OFF_W-1:0] > off_lim)) ?
                   off_lim : div_q[OFF_W-1:0];
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mop_r        <= lsf_pkg::OP_N_SXY;
      dop_r        <= lsf_pkg::DV_NX;
      cnt_r        <= '0;
      sx_r         <= '0;
      sy_r         <= '0;
      sxx_r        <= '0;
      sxy_r        <= '0;
      prod_r       <= '0;
      add_r        <= 1'b0;
      last_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          // The x*y product of the previous item lands here.
          sxy_r  <= sxy_r + SQ_W'(prod_r);
          prod_r <= in_acc ? pm_p : '0;
          if (in_acc) begin
            x_r    <= in_x;
            y_r    <= in_y;
            add_r  <= can_add;
            last_r <= in_tlast;
            if (can_add) begin
              cnt_r <= cnt_r + 1'b1;
              sx_r  <= sx_r + SUM_W'(in_x);
              sy_r  <= sy_r + SUM_W'(in_y);
            end
            state_r <= ST_XY;
          end
        end
        ST_XY: begin
          if (add_r) begin
            sxx_r <= sxx_r + SQ_W'(prod_r);
          end
          prod_r  <= add_r ? pm_p : '0;
          state_r <= last_r ? ST_SXY : ST_IDLE;
        end
        ST_SXY: begin
          sxy_r   <= sxy_r + SQ_W'(prod_r);
          prod_r  <= '0;
          mop_r   <= lsf_pkg::OP_N_SXY;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_MULW;
        end
        ST_MULW: begin
          if (mul_done) begin
            state_r <= ST_MUL;
            unique case (mop_r)
              lsf_pkg::OP_N_SXY, lsf_pkg::OP_N_SXX, lsf_pkg::OP_SXX_SY,
              lsf_pkg::OP_NA_SQ: begin
                t_r   <= mul_p;
                mop_r <= lsf_pkg::mul_op_t'(mop_r + 1'b1);
              end
              lsf_pkg::OP_SX_SY: begin
                na_neg_r <= diff[PROD_W-1];
                ma_r     <= diff_mag;
                mop_r    <= lsf_pkg::OP_N_SXX;
              end
              lsf_pkg::OP_SX_SX: begin
                deg_r  <= (diff == '0);
                flip_r <= diff[PROD_W-1];
                md_r   <= diff_mag;
                mop_r  <= lsf_pkg::OP_SXX_SY;
              end
              lsf_pkg::OP_SX_SXY: begin
                mc_r     <= NUM_W'(diff_mag);
                nc_neg_r <= diff[PROD_W-1] ^ flip_r;
                // The sums are no longer needed: start the next set.
                cnt_r    <= '0;
                sx_r     <= '0;
                sy_r     <= '0;
                sxx_r    <= '0;
                sxy_r    <= '0;
                state_r  <= deg_r ? ST_OUT : ST_NORM;
              end
              lsf_pkg::OP_D_SQ: begin
                v_r     <= t_r[SQR_W-1:0] + mul_p[SQR_W-1:0];
                res_r   <= '0;
                bit_r   <= {2'b01, {(SQR_W-2){1'b0}}};
                state_r <= ST_SQRT;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_NORM: begin
          priority if (norm_big) begin
            ma_r <= {1'b0, ma_r[PROD_W-1:1]};
            md_r <= {1'b0, md_r[PROD_W-1:1]};
            mc_r <= {1'b0, mc_r[NUM_W-1:1]};
          end else if (norm_small) begin
            ma_r <= {ma_r[PROD_W-2:0], 1'b0};
            md_r <= {md_r[PROD_W-2:0], 1'b0};
            mc_r <= {mc_r[NUM_W-2:0], 1'b0};
          end else begin
            mop_r   <= lsf_pkg::OP_NA_SQ;
            state_r <= ST_MUL;
          end
        end
        ST_SQRT: begin
          if (v_r >= trial) begin
            v_r   <= v_r - trial;
            res_r <= {1'b0, res_r[SQR_W-1:1]} + bit_r;
          end else begin
            res_r <= {1'b0, res_r[SQR_W-1:1]};
          end
          bit_r <= {2'b00, bit_r[SQR_W-1:2]};
          if (bit_r[0]) begin
            dop_r   <= lsf_pkg::DV_NX;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            state_r <= ST_DIV;
            unique case (dop_r)
              lsf_pkg::DV_NX: begin
                nx_r  <= (na_neg_r ^ flip_r) ? -NRM_W'(div_q) : NRM_W'(div_q);
                dop_r <= lsf_pkg::DV_NY;
              end
              lsf_pkg::DV_NY: begin
                ny_r  <= -NRM_W'(div_q);
                dop_r <= lsf_pkg::DV_OFF;
              end
              lsf_pkg::DV_OFF: begin
                off_r   <= nc_neg_r ? -off_mag : off_mag;
                state_r <= ST_OUT;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            if (deg_r) begin
              out_tdata_r <= {{OFF_W{1'b0}}, -NRM_W'(64'd1 << NORM_LO), {NRM_W{1'b0}}};
              out_tuser_r <= 1'b1;
            end else begin
              out_tdata_r <= {off_r, ny_r, nx_r};
              out_tuser_r <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- sim/testbench.sv -----
// Testbench for least_squares_line_fit: streams point sets and checks each fitted line.
// Depends on lsf_pkg and the least_squares_line_fit RTL; the expected lines come from a
// bit-exact fixed-point predictor kept in this file.
module testbench;

  typedef struct packed {
    logic [lsf_pkg::OFF_W-1:0] offset;
    logic [lsf_pkg::NRM_W-1:0] ny;
    logic [lsf_pkg::NRM_W-1:0] nx;
    logic                      degen;
  } line_t;

  localparam int unsigned POINT_LIMIT = 65536;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [39:0]    in_tdata = '0;
  logic           in_tlast = 1'b0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [111:0]   out_tdata;
  logic [0:0]     out_tuser;

  // Predictor copy of the block's accumulators.
  logic [16:0]        fit_count;
  logic signed [35:0] fit_sx, fit_sy;
  logic signed [55:0] fit_sxx, fit_sxy;

  line_t pending_lines[$];
  int    mismatches = 0;
  bit    calm = 1'b0;
  int    hold_left = 0;

  least_squares_line_fit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 1500000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned bit_length(logic [127:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 128; i++)
      if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Solves the normal equations on the current sums and returns the normalized line.
  function automatic line_t fit_line();
    logic signed [127:0] n, sx, sy, sxx, sxy, num_a, det, num_c;
    logic [127:0] ma, md, mc, qo, lim;
    logic [63:0]  na, d, r, qx, qy;
    int unsigned  len;
    bit           flip, cneg;
    line_t        res;
    n = 128'(fit_count); sx = 128'(fit_sx); sy = 128'(fit_sy);
    sxx = 128'(fit_sxx); sxy = 128'(fit_sxy);
    num_a = n * sxy - sx * sy;
    det   = n * sxx - sx * sx;
    num_c = sxx * sy - sx * sxy;
    res = '0;
    if (det == 0) begin
      res.ny = -(32'sd1 <<< lsf_pkg::NORM_LO);
      res.degen = 1'b1;
      return res;
    end
    flip = det < 0;
    ma = num_a < 0 ? -num_a : num_a;
    md = det < 0 ? -det : det;
    mc = num_c < 0 ? -num_c : num_c;
    cneg = (num_c < 0) != flip;
    len = bit_length(ma) > bit_length(md) ? bit_length(ma) : bit_length(md);
    if (len > 31) begin
      ma = ma >> (len - 31); md = md >> (len - 31); mc = mc >> (len - 31);
    end else begin
      ma = ma << (31 - len); md = md << (31 - len); mc = mc << (31 - len);
    end
    na = ma[63:0];
    d  = md[63:0];
    r  = int_sqrt(na * na + d * d);
    qx = ((na << 30) + (r >> 1)) / r;
    qy = ((d << 30) + (r >> 1)) / r;
    res.nx = ((num_a < 0) != flip) ? -qx[31:0] : qx[31:0];
    res.ny = -qy[31:0];
    qo = (mc + (r >> 1)) / r;
    lim = cneg ? (128'd1 << 47) : (128'd1 << 47) - 1;
    if (qo > lim) qo = lim;
    res.offset = cneg ? -qo[47:0] : qo[47:0];
    return res;
  endfunction

  function automatic void clear_sums();
    fit_count = '0; fit_sx = '0; fit_sy = '0; fit_sxx = '0; fit_sxy = '0;
  endfunction

  function automatic void accept_point(logic signed [19:0] x, logic signed [19:0] y,
                                       logic last);
    logic signed [55:0] xe, ye;
    xe = 56'(x);
    ye = 56'(y);
    if (fit_count < POINT_LIMIT) begin
      fit_count = fit_count + 17'd1;
      fit_sx  = fit_sx + x;
      fit_sy  = fit_sy + y;
      fit_sxx = fit_sxx + xe * xe;
      fit_sxy = fit_sxy + xe * ye;
    end
    if (last) begin
      pending_lines.push_back(fit_line());
      clear_sums();
    end
  endfunction

  // Offers one point and returns once the block has taken it.
  task automatic send_point(logic signed [19:0] x, logic signed [19:0] y, logic last);
    if (!calm && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    accept_point(x, y, last);
  endtask

  function automatic logic signed [19:0] pick_coord();
    case ($urandom_range(3))
      0: return 20'($urandom);
      1: return $urandom_range(1) ? 20'sh7FFFF - $signed(20'($urandom_range(15)))
                                  : -20'sh80000 + $signed(20'($urandom_range(15)));
      default: return $signed(20'($urandom_range(8191))) - 20'sd4096;
    endcase
  endfunction

  task automatic send_set(int unsigned size, bit same_x);
    logic signed [19:0] x0;
    x0 = pick_coord();
    for (int unsigned i = 0; i < size; i++)
      send_point(same_x ? x0 : pick_coord(), pick_coord(), i == size - 1);
  endtask

  task automatic test_directed();
    send_point(20'sd100, 20'sd50, 1'b1);                 // single point: degenerate
    send_point(-20'sh80000, -20'sh80000, 1'b0);
    send_point(20'sh7FFFF, 20'sh7FFFF, 1'b1);            // full-range diagonal
    send_point(20'sh7FFFF, -20'sh80000, 1'b0);
    send_point(-20'sh80000, 20'sh7FFFF, 1'b1);           // full-range negative diagonal
    for (int i = 0; i < 4; i++)                          // all x equal
      send_point(-20'sd33, 20'(20'sd7 * i), i == 3);
    for (int i = 0; i < 5; i++)                          // exact line y = 3x - 20
      send_point(20'(20'sd16 * i), 20'(20'sd48 * i - 20'sd20), i == 4);
    send_point(20'sd0, 20'sh7FFFF, 1'b0);                // horizontal fit, large offset
    send_point(20'sd1, -20'sh80000, 1'b0);
    send_point(20'sd2, 20'sh7FFFF, 1'b1);
    send_point(-20'sd5, 20'sd0, 1'b0);                   // horizontal line y = 0
    send_point(20'sd9, 20'sd0, 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    sent = 0;
    while (sent < 1500) begin
      int unsigned size;
      size = $urandom_range(99) < 85 ? $urandom_range(24, 1) : $urandom_range(120, 25);
      calm = sent > 600 && sent < 800;
      send_set(size, $urandom_range(9) == 0);
      sent += size;
    end
    calm = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_left = 3000;
    for (int i = 0; i < 6; i++)
      send_set($urandom_range(6, 2), 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= calm || $urandom_range(99) >= 11;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      line_t got, want;
      got = {out_tdata[111:64], out_tdata[63:32], out_tdata[31:0], out_tuser[0]};
      if (pending_lines.size() == 0) begin
        $display("%0t: unexpected line, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_lines.pop_front();
        if (got.nx !== want.nx) begin
          $display("%0t: normal_x expected %h actual %h", $time, want.nx, got.nx);
          mismatches++;
        end
        if (got.ny !== want.ny) begin
          $display("%0t: normal_y expected %h actual %h", $time, want.ny, got.ny);
          mismatches++;
        end
        if (got.offset !== want.offset) begin
          $display("%0t: line_offset expected %h actual %h", $time, want.offset,
                   got.offset);
          mismatches++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degen, got.degen);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clear_sums();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sets();
    test_output_stall();
    in_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lsf_pkg.sv
hdl/lsf_mul.sv
hdl/lsf_div.sv
hdl/least_squares_line_fit.sv
sim/testbench.sv
